FILE: hdl/rmmn_pkg.sv
// Shared constants and controller/datapath interface types for the min/max normalizer.
package rmmn_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  typedef struct packed {
    logic load;
    logic prep;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;
  } dp_sts_t;

endpackage

FILE: hdl/rmmn_datapath.sv
// Datapath: running min/max marks, restoring divider, published values and output register.
module rmmn_datapath
  import rmmn_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd,
  output dp_sts_t                       sts,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          sample_ok,
  input  logic                          clear_request,
  output logic signed [SAMPLE_BITS-1:0] running_min,
  output logic signed [SAMPLE_BITS-1:0] running_max,
  output logic        [FRAC_BITS:0]     normalized,
  output logic                          min_changed,
  output logic                          max_changed,
  output logic                          norm_changed
);

  localparam int SB = SAMPLE_BITS;
  localparam int FB = FRAC_BITS;
  localparam int CW = $clog2(FB + 1);

  logic signed [SB-1:0] low_r, low_nxt;
  logic signed [SB-1:0] high_r, high_nxt;
  logic                 have_r, have_nxt;
  logic signed [SB-1:0] smp_r;
  logic        [SB-1:0] div_r;
  logic        [SB-1:0] rem_r;
  logic        [FB:0]   quo_r;
  logic        [CW-1:0] cnt_r;
  logic signed [SB-1:0] pub_min_r;
  logic signed [SB-1:0] pub_max_r;
  logic        [FB:0]   pub_norm_r;
  logic signed [SB-1:0] omin_r;
  logic signed [SB-1:0] omax_r;
  logic        [FB:0]   onorm_r;
  logic        [2:0]    oflag_r;

  logic                 eff_have;
  logic        [SB:0]   range_ext;
  logic        [SB:0]   off_ext;
  logic                 first_step;
  logic        [SB:0]   trial;
  logic                 ge;
  logic        [SB:0]   diff;
  logic        [FB:0]   norm_w;

  // fold the accepted item into the marks; a clear takes effect first
  always_comb begin
    eff_have = have_r & ~clear_request;
    low_nxt  = low_r;
    high_nxt = high_r;
    have_nxt = have_r;
    if (cmd.load) begin
      if (sample_ok) begin
        if (!eff_have || sample < low_r) low_nxt = sample;
        if (!eff_have || sample > high_r) high_nxt = sample;
        have_nxt = 1'b1;
      end else if (clear_request) begin
        low_nxt  = '0;
        high_nxt = '0;
        have_nxt = 1'b0;
      end
    end
  end

  assign range_ext = {high_r[SB-1], high_r} - {low_r[SB-1], low_r};
  assign off_ext   = {smp_r[SB-1], smp_r} - {low_r[SB-1], low_r};

  // integer quotient bit first (no shift), then one fraction bit per step
  assign first_step = (cnt_r == CW'(FB));
  assign trial      = first_step ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign ge         = (trial >= {1'b0, div_r});
  assign diff       = trial - {1'b0, div_r};
  assign norm_w     = (div_r == '0) ? '0 : quo_r;

  assign sts.div_last = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r      <= '0;
      high_r     <= '0;
      have_r     <= 1'b0;
      cnt_r      <= '0;
      pub_min_r  <= '0;
      pub_max_r  <= '0;
      pub_norm_r <= '0;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
      have_r <= have_nxt;
      if (cmd.prep) begin
        cnt_r <= CW'(FB);
      end else if (cmd.step && cnt_r != '0) begin
        cnt_r <= cnt_r - CW'(1);
      end
      if (cmd.finish) begin
        pub_min_r  <= low_r;
        pub_max_r  <= high_r;
        pub_norm_r <= norm_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp_r <= sample;
    end
    if (cmd.prep) begin
      div_r <= range_ext[SB-1:0];
      rem_r <= off_ext[SB-1:0];
      quo_r <= '0;
    end else if (cmd.step) begin
      rem_r <= ge ? diff[SB-1:0] : trial[SB-1:0];
      quo_r <= {quo_r[FB-1:0], ge};
    end
    if (cmd.finish) begin
      omin_r  <= low_r;
      omax_r  <= high_r;
      onorm_r <= norm_w;
      oflag_r <= {norm_w != pub_norm_r, high_r != pub_max_r, low_r != pub_min_r};
    end
  end

  assign running_min  = omin_r;
  assign running_max  = omax_r;
  assign normalized   = onorm_r;
  assign min_changed  = oflag_r[0];
  assign max_changed  = oflag_r[1];
  assign norm_changed = oflag_r[2];

`ifndef SYNTHESIS
  a_rem_below_divisor : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && div_r != '0) |=> (rem_r < div_r))
    else $error("divider remainder not below range");
  a_marks_ordered : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (have_r && low_r <= high_r && smp_r >= low_r && smp_r <= high_r))
    else $error("marks inconsistent at finish");
  a_norm_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (norm_w <= ((FB+1)'(1) << FB)))
    else $error("normalized value above one");
`endif

endmodule

FILE: hdl/rmmn_ctrl.sv
// Controller: sequences load, divider setup, quotient steps and result hand-off.
module rmmn_ctrl
  import rmmn_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_ok,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PREP = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign in_tready = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_ok) state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  a_result_from_fin : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result raised outside finish");
  a_div_progress : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> (state_r == S_DIV || state_r == S_FIN))
    else $error("divider left early");
  a_fin_waits : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && !out_tready) |=> (state_r == S_FIN))
    else $error("finish overwrote pending result");
`endif

endmodule

FILE: hdl/running_min_max_normalizer_unit.sv
// Top level of the running min/max normalizer.
//
//  channel | dir | handshake          | tdata                      | tuser
//  in_     | in  | in_tvalid/tready   | sample                     | sample_ok, clear_request
//  out_    | out | out_tvalid/tready  | running_min, max, normal.  | min/max/norm_changed
//
//  Valid sample: load, divider setup, FRAC_BITS+1 quotient bits from the restoring
//  divider, output load; no new sample is taken until the result is handed off.
//  Invalid sample: taken with no result; next item the following cycle.
//  A finished result waits in the output register; the divider holds its final
//  state only while that register is still occupied.
//  rst_n (synchronous) clears marks, have-value flag and published values.
module running_min_max_normalizer_unit
  import rmmn_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF,
  localparam int IN_DW  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_DW = ((2 * SAMPLE_BITS + FRAC_BITS + 1 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // sample
  input  logic [1:0]        in_tuser,   // sample_ok, clear_request
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // running_min, running_max, normalized
  output logic [2:0]        out_tuser   // min_changed, max_changed, norm_changed
);

  dp_cmd_t                       cmd;
  dp_sts_t                       sts;
  logic signed [SAMPLE_BITS-1:0] rmin;
  logic signed [SAMPLE_BITS-1:0] rmax;
  logic        [FRAC_BITS:0]     rnorm;
  logic                          cmin;
  logic                          cmax;
  logic                          cnorm;

  rmmn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_ok      (in_tuser[0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  rmmn_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .sample        (in_tdata[SAMPLE_BITS-1:0]),
    .sample_ok     (in_tuser[0]),
    .clear_request (in_tuser[1]),
    .running_min   (rmin),
    .running_max   (rmax),
    .normalized    (rnorm),
    .min_changed   (cmin),
    .max_changed   (cmax),
    .norm_changed  (cnorm)
  );

  assign out_tdata = OUT_DW'({rnorm, rmax, rmin});
  assign out_tuser = {cnorm, cmax, cmin};

endmodule

FILE: dv/running_min_max_normalizer_checker.sv
// Checker for the min/max normalizer: predicts each result and compares it with the out channel.
`timescale 1ns / 100ps

module running_min_max_normalizer_checker
  import rmmn_pkg::*;
#(
  localparam int SB     = SAMPLE_BITS_DEF,
  localparam int FB     = FRAC_BITS_DEF,
  localparam int IN_DW  = ((SB + 7) / 8) * 8,
  localparam int OUT_DW = ((2 * SB + FB + 1 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // sample
  input  logic [1:0]        in_tuser,   // sample_ok, clear_request
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,  // running_min, running_max, normalized
  input  logic [2:0]        out_tuser,  // min_changed, max_changed, norm_changed
  output int                mismatch_count,
  output int                results_outstanding,
  output int                results_checked
);

  typedef struct {
    logic signed [SB-1:0] lo;
    logic signed [SB-1:0] hi;
    logic [FB:0]          norm;
    logic                 lo_chg;
    logic                 hi_chg;
    logic                 norm_chg;
  } min_max_result_t;

  min_max_result_t      due_results[$];

  logic signed [SB-1:0] run_lo, run_hi, pub_lo, pub_hi;
  logic [FB:0]          pub_norm;
  logic                 seen_any;

  // Folds one accepted item into the running marks; returns 1 when it yields a result.
  function automatic bit fold_sample(input logic signed [SB-1:0] v, input logic ok,
                                     input logic clr, output min_max_result_t r);
    longint span, off, q;
    if (clr) begin
      seen_any = 1'b0;
      run_lo   = '0;
      run_hi   = '0;
    end
    if (!ok) return 1'b0;
    if (!seen_any || v < run_lo) run_lo = v;
    if (!seen_any || v > run_hi) run_hi = v;
    seen_any = 1'b1;

    span = longint'(run_hi) - longint'(run_lo);
    if (span != 0) begin
      off = longint'(v) - longint'(run_lo);
      q   = (off <<< FB) / span;
    end else begin
      q = 0;
    end

    r.lo       = run_lo;
    r.hi       = run_hi;
    r.norm     = q[FB:0];
    r.lo_chg   = run_lo != pub_lo;
    r.hi_chg   = run_hi != pub_hi;
    r.norm_chg = r.norm != pub_norm;
    if (r.lo_chg) pub_lo = run_lo;
    if (r.hi_chg) pub_hi = run_hi;
    if (r.norm_chg) pub_norm = r.norm;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    min_max_result_t want, fresh;
    if (!rst_n) begin
      run_lo          = '0;
      run_hi          = '0;
      pub_lo          = '0;
      pub_hi          = '0;
      pub_norm        = '0;
      seen_any        = 1'b0;
      mismatch_count  = 0;
      results_checked = 0;
      due_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $error("result item with no expectation pending: tdata %h tuser %b",
                 out_tdata, out_tuser);
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          check_field("running_min", want.lo, $signed(out_tdata[SB-1:0]));
          check_field("running_max", want.hi, $signed(out_tdata[2*SB-1:SB]));
          check_field("normalized", want.norm, out_tdata[2*SB+FB:2*SB]);
          check_field("tdata padding", 64'sd0, out_tdata[OUT_DW-1:2*SB+FB+1]);
          check_field("min_changed", want.lo_chg, out_tuser[0]);
          check_field("max_changed", want.hi_chg, out_tuser[1]);
          check_field("norm_changed", want.norm_chg, out_tuser[2]);
          results_checked++;
        end
      end
      if (in_tvalid && in_tready) begin
        if (fold_sample($signed(in_tdata[SB-1:0]), in_tuser[0], in_tuser[1], fresh))
          due_results.push_back(fresh);
      end
    end
    results_outstanding = due_results.size();
  end

endmodule

FILE: dv/tb_running_min_max_normalizer_unit.sv
// Testbench top for the min/max normalizer: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_running_min_max_normalizer_unit;
  import rmmn_pkg::*;

  localparam int SB           = SAMPLE_BITS_DEF;
  localparam int FB           = FRAC_BITS_DEF;
  localparam int IN_DW        = ((SB + 7) / 8) * 8;
  localparam int OUT_DW       = ((2 * SB + FB + 1 + 7) / 8) * 8;
  localparam int N_ITEMS      = 950;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE       = 2 * (FB + 4);
  localparam int CYCLE_LIMIT  = 500000;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;   // sample
  logic [1:0]        in_tuser;   // sample_ok, clear_request
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;  // running_min, running_max, normalized
  logic [2:0]        out_tuser;  // min_changed, max_changed, norm_changed

  int mismatch_count, results_outstanding, results_checked;
  int items_sent, valid_sent, clears_sent, burst_left, cycle_count, cluster_center;
  bit quiet, rx_hold_req;

  running_min_max_normalizer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  running_min_max_normalizer_checker checker_i (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .in_tuser            (in_tuser),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_tdata           (out_tdata),
    .out_tuser           (out_tuser),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding),
    .results_checked     (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("timeout after %0d cycles, %0d results still due", cycle_count,
             results_outstanding);
    $display("tb_running_min_max_normalizer_unit NOT OK");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [IN_DW-1:0] pick_sample();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return IN_DW'($urandom_range(0, 65535));
    if (sel < 7) return IN_DW'(cluster_center + int'($urandom_range(0, 40)) - 20);
    if (sel == 7) return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
    if (sel == 8) return IN_DW'(int'($urandom_range(0, 2)) - 1);
    return IN_DW'(int'($urandom_range(0, 255)) - 128);
  endfunction

  // Called at a falling edge; returns at a falling edge after the item is taken.
  task automatic send_item(input logic [IN_DW-1:0] s, input logic ok, input logic clr);
    int gap;
    in_tdata  <= s;
    in_tuser  <= {clr, ok};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (ok) valid_sent++;
    if (clr) clears_sent++;
    @(negedge clk);
    gap = (quiet || burst_left > 0) ? 0 : pick_gap();
    if (burst_left > 0) burst_left--;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin : receiver
    int stall;
    stall      = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        rx_hold_req = 1'b0;
      end
      if (stall == 0 && !quiet && $urandom_range(0, 3) == 0) stall = pick_gap();
      if (quiet) stall = 0;
      out_tready <= (stall == 0);
      if (stall > 0) stall--;
    end
  end

  initial begin : stimulus
    bit ok, clr;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: -1 as first value, zero range, extremes, invalid items, clears
    send_item(16'hffff, 1'b1, 1'b0);
    send_item(16'hffff, 1'b1, 1'b0);
    send_item(16'h0000, 1'b1, 1'b0);
    send_item(16'hffff, 1'b1, 1'b0);
    send_item(16'h7fff, 1'b1, 1'b0);
    send_item(16'h8000, 1'b1, 1'b0);
    send_item(16'h0000, 1'b1, 1'b0);
    send_item(16'h7fff, 1'b1, 1'b0);
    send_item(16'h0005, 1'b0, 1'b0);
    send_item(16'h0007, 1'b0, 1'b1);
    send_item(16'd100, 1'b1, 1'b0);
    send_item(16'd100, 1'b1, 1'b1);
    send_item(16'hffff, 1'b1, 1'b1);
    send_item(16'h5555, 1'b1, 1'b0);
    send_item(16'haaaa, 1'b1, 1'b0);
    send_item(16'd200, 1'b1, 1'b0);
    send_item(16'd150, 1'b1, 1'b0);
    send_item(16'h8000, 1'b1, 1'b1);
    send_item(16'h8000, 1'b1, 1'b0);
    send_item(16'h7fff, 1'b1, 1'b0);
    send_item(16'h8000, 1'b1, 1'b0);

    cluster_center = int'($urandom_range(0, 65535)) - 32768;
    while (items_sent < N_ITEMS) begin
      if (items_sent == 250) begin
        rx_hold_req = 1'b1;
        burst_left  = 40;
      end
      if (items_sent == 450) quiet = 1'b1;
      if (items_sent == 530) quiet = 1'b0;
      if (items_sent == 650) begin
        in_tvalid <= 1'b0;
        while (results_outstanding != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
      end
      clr = ($urandom_range(0, 14) == 0);
      ok  = ($urandom_range(0, 9) != 0);
      if (clr) cluster_center = int'($urandom_range(0, 65535)) - 32768;
      send_item(pick_sample(), ok, clr);
    end
    in_tvalid <= 1'b0;

    while (results_outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);

    $display("%0d items sent (%0d valid, %0d with clear), %0d results checked,",
             items_sent, valid_sent, clears_sent, results_checked);
    $display("including a %0d-cycle output hold-off and a full drain pause", HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("tb_running_min_max_normalizer_unit OK");
    end else begin
      $display("tb_running_min_max_normalizer_unit NOT OK");
    end
    $finish;
  end

endmodule
